// ----- hdl/mrlr_pkg.sv -----
`default_nettype none
package mrlr_pkg;

  localparam int MAX_LINE_DEFAULT = 90;
  localparam int LEN_W            = 7;
  localparam int WORD_COUNT       = 20;
  localparam int RING_INDEX       = 19;
  localparam int MAX_WORD_LEN     = 13;
  localparam int CODE_W           = 5;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [CODE_W-1:0] CODE_NO_CARRIER = 5'd12;
  localparam logic [CODE_W-1:0] CODE_NO_ANSWER  = 5'd15;
  localparam logic [CODE_W-1:0] CODE_VOICE      = 5'd16;
  localparam logic [CODE_W-1:0] CODE_NONE       = 5'd17;

  // Text is right-justified: the last character sits in the low byte.
  localparam logic [MAX_WORD_LEN*8-1:0] WORD_TEXT [WORD_COUNT] = '{
    104'("CONNECT"),
    104'("CONNECT 300"),
    104'("CONNECT 1200"),
    104'("CONNECT 1275"),
    104'("CONNECT 2400"),
    104'("CONNECT 4800"),
    104'("CONNECT 7200"),
    104'("CONNECT 9600"),
    104'("CONNECT FAST"),
    104'("CONNECT 12000"),
    104'("CONNECT 14400"),
    104'("CONNECT 19200"),
    104'("CONNECT 38400"),
    104'("OK"),
    104'("NO CARRIER"),
    104'("NO DIALTONE"),
    104'("BUSY"),
    104'("NO ANSWER"),
    104'("VOICE"),
    104'("RING")
  };

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd7, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd12, 4'd13,
    4'd13, 4'd13, 4'd13, 4'd2, 4'd10, 4'd11, 4'd4, 4'd9, 4'd5, 4'd4
  };

  localparam logic [CODE_W-1:0] WORD_CODE [WORD_COUNT] = '{
    5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd7, 5'd8,
    5'd9, 5'd10, 5'd11, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17
  };

endpackage
`default_nettype wire

// ----- hdl/mrlr_match.sv -----
`default_nettype none
module mrlr_match (
  input  wire logic [mrlr_pkg::WORD_COUNT-1:0] alive,
  input  wire logic [mrlr_pkg::LEN_W-1:0]      pos,
  input  wire logic [7:0]                      ch,
  output logic      [mrlr_pkg::WORD_COUNT-1:0] alive_next
);

  logic [7:0] up;

  always_comb begin
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      up = ch - 8'h20;
    end else begin
      up = ch;
    end
  end

  for (genvar k = 0; k < mrlr_pkg::WORD_COUNT; k++) begin : g_word
    localparam int LEN = int'(mrlr_pkg::WORD_LEN[k]);
    logic [7:0] chars [mrlr_pkg::MAX_WORD_LEN];
    logic       in_word;
    logic       hit;

    for (genvar j = 0; j < mrlr_pkg::MAX_WORD_LEN; j++) begin : g_char
      if (j < LEN) begin : g_real
        assign chars[j] = mrlr_pkg::WORD_TEXT[k][(LEN-1-j)*8 +: 8];
      end else begin : g_pad
        assign chars[j] = 8'h00;
      end
    end

    assign in_word = (pos < mrlr_pkg::LEN_W'(LEN));
    assign hit     = in_word && (up == chars[pos[3:0]]);

    if (k == mrlr_pkg::RING_INDEX) begin : g_prefix
      // prefix word: stays alive once fully matched
      assign alive_next[k] = alive[k] && (!in_word || hit);
    end else begin : g_exact
      assign alive_next[k] = alive[k] && hit;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/modem_result_line_recognizer.sv -----
`default_nettype none
// Modem result line recognizer. One received byte (tuser 0) or hangup event (tuser 1)
// per input item, one result item per input item. Bytes are assembled into a line ended
// by CR or by the MAX_LINE-th stored character; the text before the first '/' is matched,
// case-insensitive, against the Hayes result words and a RING prefix. Each item passes an
// input register and a result register, and a new item is taken every cycle unless the
// output stalls; the whole word match and state update sit between the two registers.
// A first RING sets answer_request; NO CARRIER, NO ANSWER, VOICE or a hangup re-arm it.
module modem_result_line_recognizer #(
  parameter int MAX_LINE = mrlr_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  input  wire logic       s_tuser,   // [0] mode
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [4:0] result_code, [5] answer_request, [7:6] zero
  output logic            m_tlast    // line_done
);

  localparam int LW = mrlr_pkg::LEN_W;
  localparam int WC = mrlr_pkg::WORD_COUNT;
  localparam int RI = mrlr_pkg::RING_INDEX;

  logic        in_valid;
  logic        in_mode;
  logic [7:0]  in_byte;

  logic        out_valid;
  logic        out_last;
  logic [4:0]  out_code;
  logic        out_ans;

  logic [LW-1:0] line_length;
  logic [LW-1:0] compare_length;
  logic          slash_seen;
  logic [WC-1:0] pattern_alive;
  logic          answering;

  logic          adv;
  logic          is_char;
  logic          cmp_inc;
  logic [WC-1:0] alive_match;
  logic [WC-1:0] alive_next;
  logic [LW-1:0] cmp_next;
  logic [LW-1:0] len_next;
  logic          slash_next;
  logic          finish;
  logic          long_line;
  logic [4:0]    code;
  logic          ring_req;
  logic          clr_answer;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_ans, out_code};

  mrlr_match u_match (
    .alive      (pattern_alive),
    .pos        (compare_length),
    .ch         (in_byte),
    .alive_next (alive_match)
  );

  always_comb begin
    is_char    = !in_mode && (in_byte >= mrlr_pkg::CHAR_SPACE);
    cmp_inc    = is_char && !slash_seen && (in_byte != mrlr_pkg::CHAR_SLASH);
    alive_next = cmp_inc ? alive_match : pattern_alive;
    cmp_next   = cmp_inc ? compare_length + 1'b1 : compare_length;
    slash_next = slash_seen || (is_char && (in_byte == mrlr_pkg::CHAR_SLASH));
    len_next   = is_char ? line_length + 1'b1 : line_length;
    finish     = (!in_mode && (in_byte == mrlr_pkg::CHAR_CR))
                 || (is_char && (len_next >= LW'(MAX_LINE)));
    long_line  = finish && (len_next >= LW'(2));

    // first alive exact word wins
    code = mrlr_pkg::CODE_NONE;
    for (int k = RI - 1; k >= 0; k--) begin
      if (alive_next[k] && (cmp_next == LW'(mrlr_pkg::WORD_LEN[k]))) begin
        code = mrlr_pkg::WORD_CODE[k];
      end
    end
    if (!long_line) begin
      code = mrlr_pkg::CODE_NONE;
    end

    clr_answer = long_line && ((code == mrlr_pkg::CODE_NO_CARRIER)
                 || (code == mrlr_pkg::CODE_NO_ANSWER) || (code == mrlr_pkg::CODE_VOICE));
    ring_req   = long_line && (code == mrlr_pkg::CODE_NONE) && alive_next[RI]
                 && (cmp_next >= LW'(mrlr_pkg::WORD_LEN[RI])) && !answering;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last <= finish;
      out_code <= code;
      out_ans  <= ring_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      compare_length <= '0;
      slash_seen     <= 1'b0;
      pattern_alive  <= '1;
      answering      <= 1'b0;
    end else if (adv) begin
      if (finish) begin
        line_length    <= '0;
        compare_length <= '0;
        slash_seen     <= 1'b0;
        pattern_alive  <= '1;
      end else begin
        line_length    <= len_next;
        compare_length <= cmp_next;
        slash_seen     <= slash_next;
        pattern_alive  <= alive_next;
      end
      if (in_mode || clr_answer) begin
        answering <= 1'b0;
      end else if (ring_req) begin
        answering <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/result_line_checker.sv -----
module result_line_checker #(
  parameter int MAX_LINE = mrlr_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tuser,
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,
  input  wire logic       m_tlast,
  output int              mismatches,
  output int              outstanding
);
  import mrlr_pkg::*;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] code;
    logic              answer;
  } line_verdict_t;

  string hayes_text [WORD_COUNT] = '{
    "CONNECT", "CONNECT 300", "CONNECT 1200", "CONNECT 1275", "CONNECT 2400",
    "CONNECT 4800", "CONNECT 7200", "CONNECT 9600", "CONNECT FAST", "CONNECT 12000",
    "CONNECT 14400", "CONNECT 19200", "CONNECT 38400", "OK", "NO CARRIER",
    "NO DIALTONE", "BUSY", "NO ANSWER", "VOICE", "RING"
  };
  logic [CODE_W-1:0] hayes_code [WORD_COUNT] = '{
    5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd7, 5'd8,
    5'd9, 5'd10, 5'd11, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, CODE_NONE
  };

  logic [LEN_W-1:0]      line_len  = '0;
  logic [LEN_W-1:0]      cmp_len   = '0;
  logic                  slash     = 1'b0;
  logic [WORD_COUNT-1:0] alive     = '1;
  logic                  answering = 1'b0;

  line_verdict_t line_verdicts [$];
  int results_seen = 0;

  task automatic close_line(inout line_verdict_t v);
    v.done = 1'b1;
    if (line_len >= 2) begin
      for (int k = 0; k < RING_INDEX; k++) begin
        if (v.code == CODE_NONE && alive[k] && cmp_len == hayes_text[k].len())
          v.code = hayes_code[k];
      end
      if (v.code inside {CODE_NO_CARRIER, CODE_NO_ANSWER, CODE_VOICE})
        answering = 1'b0;
      if (v.code == CODE_NONE && alive[RING_INDEX] &&
          cmp_len >= hayes_text[RING_INDEX].len() && !answering) begin
        v.answer  = 1'b1;
        answering = 1'b1;
      end
    end
    line_len = '0;
    cmp_len  = '0;
    slash    = 1'b0;
    alive    = '1;
  endtask

  task automatic recognize_item(input logic hangup, input logic [7:0] b,
                                output line_verdict_t v);
    logic [7:0] u;
    int pos;
    v = '{done: 1'b0, code: CODE_NONE, answer: 1'b0};
    if (hangup) begin
      answering = 1'b0;
    end else if (b == CHAR_CR) begin
      close_line(v);
    end else if (b >= CHAR_SPACE) begin
      if (!slash) begin
        if (b == CHAR_SLASH) begin
          slash = 1'b1;
        end else begin
          u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
          pos = int'(cmp_len);
          for (int k = 0; k < WORD_COUNT; k++) begin
            if (alive[k] && !(k == RING_INDEX && pos >= hayes_text[k].len()) &&
                (pos >= hayes_text[k].len() || u != hayes_text[k][pos]))
              alive[k] = 1'b0;
          end
          cmp_len = cmp_len + 1'b1;
        end
      end
      line_len = line_len + 1'b1;
      if (line_len >= MAX_LINE)
        close_line(v);
    end
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < 10)
      $display("%0t result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    line_verdict_t v;
    line_verdict_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        recognize_item(s_tuser, s_tdata, v);
        line_verdicts.push_back(v);
      end
      if (m_tvalid && m_tready) begin
        if (line_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected item last=%0b data=%02h", m_tlast, m_tdata));
        end else begin
          want = line_verdicts.pop_front();
          if (m_tlast !== want.done || m_tdata[4:0] !== want.code ||
              m_tdata[5] !== want.answer || m_tdata[7:6] !== 2'b00)
            flag_mismatch($sformatf(
              "exp last=%0b code=%0d ans=%0b pad=0, got last=%0b code=%0d ans=%0b pad=%0d",
              want.done, want.code, want.answer,
              m_tlast, m_tdata[4:0], m_tdata[5], m_tdata[7:6]));
        end
        results_seen++;
      end
    end
    outstanding <= line_verdicts.size();
  end

endmodule

// ----- tb/tb_modem_result_line_recognizer.sv -----
module tb_modem_result_line_recognizer;
  import mrlr_pkg::*;

  localparam int LIMIT = 800000;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tready = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire        m_tlast;

  int mismatches;
  int outstanding;
  int cycles     = 0;
  int items_sent = 0;
  int ready_hold = 0;
  bit idling     = 1'b1;

  string hayes_word [WORD_COUNT] = '{
    "CONNECT", "CONNECT 300", "CONNECT 1200", "CONNECT 1275", "CONNECT 2400",
    "CONNECT 4800", "CONNECT 7200", "CONNECT 9600", "CONNECT FAST", "CONNECT 12000",
    "CONNECT 14400", "CONNECT 19200", "CONNECT 38400", "OK", "NO CARRIER",
    "NO DIALTONE", "BUSY", "NO ANSWER", "VOICE", "RING"
  };

  always #10 clk = ~clk;

  modem_result_line_recognizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  result_line_checker line_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!idling) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= ($urandom_range(0, 3) != 0);
      ready_hold <= pick_gap();
    end
  end

  task automatic send_item(input logic hangup, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= hangup;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++)
      send_item(1'b0, t[i]);
  endtask

  task automatic send_line(input string t);
    send_text(t);
    send_item(1'b0, CHAR_CR);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_line();
    logic [7:0] q [$];
    logic [7:0] c;
    string w;
    int r;
    int k;
    int n;
    int hang_at;
    bit end_cr;
    r       = $urandom_range(0, 99);
    k       = $urandom_range(0, WORD_COUNT - 1);
    w       = hayes_word[k];
    hang_at = -1;
    end_cr  = 1'b1;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
        c = c | 8'h20;
      q.push_back(c);
    end
    if (k == RING_INDEX && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    if (r < 55) begin
      if ($urandom_range(0, 3) == 0) begin
        q.push_back(CHAR_SLASH);
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      if ($urandom_range(0, 7) == 0) begin
        c = 8'($urandom_range(8'h00, 8'h1F));
        if (c == CHAR_CR) c = 8'h0A;
        q.insert($urandom_range(0, q.size()), c);
      end
    end else if (r < 67) begin
      n = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: q[n] = 8'($urandom_range(8'h20, 8'hFF));
        1: q.delete(n);
        default: q.push_back(8'($urandom_range(8'h20, 8'hFF)));
      endcase
    end else if (r < 75) begin
      q.delete();
      repeat ($urandom_range(0, 14)) q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 82) begin
      q.delete();
      hang_at = 0;
      end_cr  = 1'b0;
    end else if (r < 88) begin
      q.delete();
      if ($urandom_range(0, 1) == 1) q.push_back(8'($urandom_range(8'h20, 8'hFF)));
    end else if (r < 93) begin
      q.delete();
      n = $urandom_range(MAX_LINE_DEFAULT - 3, MAX_LINE_DEFAULT + 4);
      repeat (n) q.push_back(8'($urandom_range(8'h20, 8'hFF)));
    end else begin
      hang_at = $urandom_range(0, q.size());
    end
    for (int i = 0; i <= q.size(); i++) begin
      if (i == hang_at) send_item(1'b1, 8'($urandom_range(0, 255)));
      if (i < q.size()) send_item(1'b0, q[i]);
    end
    if (end_cr) send_item(1'b0, CHAR_CR);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_line("OK");
    send_line("ok");
    send_line("RING");
    send_line("Ring");
    send_line("NO CARRIER");
    send_line("RINGING/2");
    send_item(1'b1, 8'hFF);
    send_text("CONN");
    send_item(1'b1, 8'h00);
    send_line("ECT 9600/ARQ");
    send_line("connect fast");
    send_item(1'b0, CHAR_CR);
    send_line("K");
    send_text("B");
    send_item(1'b0, 8'h01);
    send_line("USY");
    send_line("VOICE");
    send_line("NO ANSWER");
    send_line("NO DIALTONE");
    send_line("CONNECT 38400");
    send_line("OKAY");
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CHAR_CR);
    // full line with a slash: ends on its own without CR
    send_text("CONNECT/");
    repeat (MAX_LINE_DEFAULT - 8) send_item(1'b0, "9");
    drain();

    while (items_sent < 900) begin
      if ($urandom_range(0, 39) == 0) idling = !idling;
      if (!paused && items_sent > 600) begin
        drain();
        paused = 1'b1;
      end
      random_line();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
